// ===== rtl/core/bezier_point_evaluator_core_assert.svh =====
// ----------------------------------------------------------------------------
// bezier point evaluator assertion macros
// immediate-consequence and next-cycle property checks on the block clock
// ----------------------------------------------------------------------------
`ifndef BEZIER_POINT_EVALUATOR_CORE_ASSERT_SVH
`define BEZIER_POINT_EVALUATOR_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BPE_ASSERT_COMB(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bpe assertion failed");
`define BPE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bpe assertion failed");
`else
`define BPE_ASSERT_COMB(label, ante, cons)
`define BPE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/core/bpe_pkg.sv =====
// ----------------------------------------------------------------------------
// bpe_pkg
// shared types, register codes and the bernstein basis table
// ----------------------------------------------------------------------------
package bpe_pkg;

    localparam int COORD_W    = 32;
    localparam int NUM_PTS    = 6;
    localparam int TAB_DEG    = 5;
    localparam int DEG_W      = 3;
    localparam int CFG_ADDR_W = 6;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_DEGREE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_ZERO = 3'd1;

    localparam logic [DEG_W-1:0] DEGREE_RESET = 3'd1;

    typedef logic signed [7:0] t_coef;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_point;

    // indexed [degree-1][power][point]
    localparam t_coef BASIS [TAB_DEG][NUM_PTS][NUM_PTS] = '{
        '{
            '{  8'sd1,   8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0 },
            '{ -8'sd1,   8'sd1,   8'sd0,   8'sd0,   8'sd0,   8'sd0 },
            '{  8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0 },
            '{  8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0 },
            '{  8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0 },
            '{  8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0 }
        },
        '{
            '{  8'sd1,   8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0 },
            '{ -8'sd2,   8'sd2,   8'sd0,   8'sd0,   8'sd0,   8'sd0 },
            '{  8'sd1,  -8'sd2,   8'sd1,   8'sd0,   8'sd0,   8'sd0 },
            '{  8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0 },
            '{  8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0 },
            '{  8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0 }
        },
        '{
            '{  8'sd1,   8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0 },
            '{ -8'sd3,   8'sd3,   8'sd0,   8'sd0,   8'sd0,   8'sd0 },
            '{  8'sd3,  -8'sd6,   8'sd3,   8'sd0,   8'sd0,   8'sd0 },
            '{ -8'sd1,   8'sd3,  -8'sd3,   8'sd1,   8'sd0,   8'sd0 },
            '{  8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0 },
            '{  8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0 }
        },
        '{
            '{  8'sd1,   8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0 },
            '{ -8'sd4,   8'sd4,   8'sd0,   8'sd0,   8'sd0,   8'sd0 },
            '{  8'sd6, -8'sd12,   8'sd6,   8'sd0,   8'sd0,   8'sd0 },
            '{ -8'sd4,  8'sd12, -8'sd12,   8'sd4,   8'sd0,   8'sd0 },
            '{  8'sd1,  -8'sd4,   8'sd6,  -8'sd4,   8'sd1,   8'sd0 },
            '{  8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0 }
        },
        '{
            '{  8'sd1,   8'sd0,   8'sd0,   8'sd0,   8'sd0,   8'sd0 },
            '{ -8'sd5,   8'sd5,   8'sd0,   8'sd0,   8'sd0,   8'sd0 },
            '{ 8'sd10, -8'sd20,  8'sd10,   8'sd0,   8'sd0,   8'sd0 },
            '{-8'sd10,  8'sd30, -8'sd30,  8'sd10,   8'sd0,   8'sd0 },
            '{  8'sd5, -8'sd20,  8'sd30, -8'sd20,   8'sd5,   8'sd0 },
            '{ -8'sd1,   8'sd5, -8'sd10,  8'sd10,  -8'sd5,   8'sd1 }
        }
    };

    // zero maps to one, anything above the build limit maps to the limit
    function automatic logic [DEG_W-1:0] clamp_degree(input logic [DEG_W-1:0] deg,
                                                       input logic [DEG_W-1:0] max_deg);
        logic [DEG_W-1:0] d;
        d = deg;
        if (d == '0) begin
            d = DEG_W'(1);
        end
        if (d > max_deg) begin
            d = max_deg;
        end
        return d;
    endfunction

endpackage

// ===== rtl/core/bpe_if.sv =====
// ----------------------------------------------------------------------------
// bpe stream interfaces
// valid/ready channels for the curve parameter and the curve point
// ----------------------------------------------------------------------------
interface bpe_param_if #(
    parameter int PARAM_W = 17
) ();
    logic               valid;
    logic               ready;
    logic [PARAM_W-1:0] param_t;

    modport source (output valid, output param_t, input ready);
    modport sink (input valid, input param_t, output ready);
endinterface

interface bpe_coord_if
    import bpe_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;

    modport source (output valid, output coord_x, output coord_y, input ready);
    modport sink (input valid, input coord_x, input coord_y, output ready);
endinterface

// ===== rtl/core/bpe_regs.sv =====
// ----------------------------------------------------------------------------
// bpe_regs
// apb register file holding the curve degree and the control points
// ----------------------------------------------------------------------------
module bpe_regs
    import bpe_pkg::*;
#(
    parameter int MAX_DEGREE = 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [CFG_ADDR_W-1:0] i_paddr,
    input  logic [CFG_DATA_W-1:0] i_pwdata,
    output logic [CFG_DATA_W-1:0] o_prdata,
    output logic                  o_pready,
    output logic [DEG_W-1:0]      o_degree,
    output t_point                o_points [MAX_DEGREE+1]
);

    localparam int NP = MAX_DEGREE + 1;

    logic [CFG_IDX_W-1:0] idx;
    logic                 wr;
    logic [DEG_W-1:0]     r_degree;
    t_point               r_points [NP];

    assign idx      = i_paddr[CFG_ADDR_W-1 -: CFG_IDX_W];
    assign wr       = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;
    assign o_degree = r_degree;
    assign o_points = r_points;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= DEGREE_RESET;
            for (int k = 0; k < NP; k++) begin
                r_points[k] <= '0;
            end
        end else if (wr) begin
            if (idx == REG_DEGREE) begin
                r_degree <= i_pwdata[DEG_W-1:0];
            end
            for (int k = 0; k < NP; k++) begin
                if (idx == REG_POINT_ZERO + CFG_IDX_W'(k)) begin
                    r_points[k] <= i_pwdata;
                end
            end
        end
    end

    always_comb begin
        o_prdata = '0;
        if (idx == REG_DEGREE) begin
            o_prdata = CFG_DATA_W'(r_degree);
        end
        for (int k = 0; k < NP; k++) begin
            if (idx == REG_POINT_ZERO + CFG_IDX_W'(k)) begin
                o_prdata = r_points[k];
            end
        end
    end

endmodule

// ===== rtl/core/bpe_powers.sv =====
// ----------------------------------------------------------------------------
// bpe_powers
// pipelined power chain 1, t, t^2 .. t^n, one rounded multiply per stage after the first stage
// ----------------------------------------------------------------------------
`include "bezier_point_evaluator_core_assert.svh"

module bpe_powers
    import bpe_pkg::*;
#(
    parameter int MAX_DEGREE    = 5,
    parameter int FRACTION_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_up_valid,
    output logic                     o_up_ready,
    input  logic [FRACTION_BITS:0]   i_t,
    output logic                     o_dn_valid,
    input  logic                     i_dn_ready,
    output logic [FRACTION_BITS:0]   o_pw [MAX_DEGREE+1]
);

    localparam int T_W = FRACTION_BITS + 1;
    localparam int P_W = 2 * T_W;
    localparam int NS  = MAX_DEGREE;
    localparam logic [T_W-1:0] ONE  = {1'b1, {FRACTION_BITS{1'b0}}};
    localparam logic [P_W-1:0] HALF = P_W'(1) << (FRACTION_BITS - 1);

    logic [NS-1:0]  r_v;
    logic [NS:0]    go;
    logic [NS-1:0]  vin;
    logic [T_W-1:0] t_sat;
    logic [P_W-1:0] prod [NS];
    logic [T_W-1:0] r_t  [NS];
    logic [T_W-1:0] r_pw [NS][MAX_DEGREE+1];

    assign t_sat = (i_t > ONE) ? ONE : i_t;

    always_comb begin
        go[NS] = i_dn_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            go[k] = !r_v[k] || go[k+1];
        end
        vin[0] = i_up_valid;
        for (int k = 1; k < NS; k++) begin
            vin[k] = r_v[k-1];
        end
        prod[0] = '0;
        for (int k = 1; k < NS; k++) begin
            prod[k] = P_W'(r_pw[k-1][k]) * P_W'(r_t[k-1]) + HALF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (go[k]) begin
                    r_v[k] <= vin[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go[0]) begin
            r_t[0]     <= t_sat;
            r_pw[0][0] <= ONE;
            r_pw[0][1] <= t_sat;
        end
        for (int k = 1; k < NS; k++) begin
            if (go[k]) begin
                r_t[k] <= r_t[k-1];
                for (int i = 0; i <= MAX_DEGREE; i++) begin
                    if (i <= k) begin
                        r_pw[k][i] <= r_pw[k-1][i];
                    end
                end
                r_pw[k][k+1] <= prod[k][FRACTION_BITS +: T_W];
            end
        end
    end

    assign o_up_ready = go[0];
    assign o_dn_valid = r_v[NS-1];
    assign o_pw       = r_pw[NS-1];

    `BPE_ASSERT_NEXT(a_pw_accept, i_up_valid && go[0], r_v[0])
    `BPE_ASSERT_COMB(a_pw_order, o_dn_valid, (o_pw[0] == ONE) && (o_pw[MAX_DEGREE] <= o_pw[1]))

endmodule

// ===== rtl/core/bpe_blend.sv =====
// ----------------------------------------------------------------------------
// bpe_blend
// basis weights, point products, pairwise sums, rounding and saturation
// ----------------------------------------------------------------------------
`include "bezier_point_evaluator_core_assert.svh"

module bpe_blend
    import bpe_pkg::*;
#(
    parameter int MAX_DEGREE    = 5,
    parameter int FRACTION_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_up_valid,
    output logic                      o_up_ready,
    input  logic [FRACTION_BITS:0]    i_pw [MAX_DEGREE+1],
    input  logic [DEG_W-1:0]          i_degree,
    input  t_point                    i_points [MAX_DEGREE+1],
    output logic                      o_dn_valid,
    input  logic                      i_dn_ready,
    output logic signed [COORD_W-1:0] o_coord_x,
    output logic signed [COORD_W-1:0] o_coord_y
);

    localparam int NP    = MAX_DEGREE + 1;
    localparam int NPAIR = (NP + 1) / 2;
    localparam int W_W   = FRACTION_BITS + 8;
    localparam int SUM_W = W_W + 3;
    localparam int PR_W  = W_W + COORD_W;
    localparam int S_W   = PR_W + 3;

    localparam int ST_W  = 0;
    localparam int ST_M  = 1;
    localparam int ST_A1 = 2;
    localparam int ST_A2 = 3;
    localparam int ST_O  = 4;
    localparam int NST   = 5;

    localparam logic signed [SUM_W-1:0] ONE_W  = SUM_W'(1) << FRACTION_BITS;
    localparam logic signed [S_W-1:0]   HALF   = S_W'(1) << (FRACTION_BITS - 1);
    localparam logic signed [S_W-1:0]   SAT_HI = {{(S_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    localparam logic signed [S_W-1:0]   SAT_LO = {{(S_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

    function automatic logic signed [COORD_W-1:0] sat_round(input logic signed [S_W-1:0] v);
        logic signed [S_W-1:0] s;
        s = v >>> FRACTION_BITS;
        if (s > SAT_HI) begin
            s = SAT_HI;
        end else if (s < SAT_LO) begin
            s = SAT_LO;
        end
        return s[COORD_W-1:0];
    endfunction

    logic [NST-1:0]           r_v;
    logic [NST:0]             go;
    logic [NST-1:0]           vin;
    logic [DEG_W-1:0]         deg_idx;
    logic signed [W_W-1:0]    n_w  [NP];
    logic signed [W_W-1:0]    r_w  [NP];
    logic signed [PR_W-1:0]   r_px [NP];
    logic signed [PR_W-1:0]   r_py [NP];
    logic signed [S_W-1:0]    n_ax [NPAIR];
    logic signed [S_W-1:0]    n_ay [NPAIR];
    logic signed [S_W-1:0]    r_ax [NPAIR];
    logic signed [S_W-1:0]    r_ay [NPAIR];
    logic signed [S_W-1:0]    n_sx;
    logic signed [S_W-1:0]    n_sy;
    logic signed [S_W-1:0]    r_sx;
    logic signed [S_W-1:0]    r_sy;
    logic signed [COORD_W-1:0] r_cx;
    logic signed [COORD_W-1:0] r_cy;
    logic signed [SUM_W-1:0]  w_total;

    assign deg_idx = clamp_degree(i_degree, DEG_W'(MAX_DEGREE)) - DEG_W'(1);

    always_comb begin
        go[NST] = i_dn_ready;
        for (int k = NST - 1; k >= 0; k--) begin
            go[k] = !r_v[k] || go[k+1];
        end
        vin[0] = i_up_valid;
        for (int k = 1; k < NST; k++) begin
            vin[k] = r_v[k-1];
        end
    end

    always_comb begin
        for (int j = 0; j < NP; j++) begin
            n_w[j] = '0;
            for (int i = 0; i < NP; i++) begin
                n_w[j] = n_w[j] + W_W'($signed({1'b0, i_pw[i]})) * W_W'(BASIS[deg_idx][i][j]);
            end
        end
        for (int p = 0; p < NPAIR; p++) begin
            n_ax[p] = S_W'(r_px[2*p]);
            n_ay[p] = S_W'(r_py[2*p]);
            if (2 * p + 1 < NP) begin
                n_ax[p] = n_ax[p] + S_W'(r_px[2*p+1]);
                n_ay[p] = n_ay[p] + S_W'(r_py[2*p+1]);
            end
        end
        n_sx = HALF;
        n_sy = HALF;
        for (int p = 0; p < NPAIR; p++) begin
            n_sx = n_sx + r_ax[p];
            n_sy = n_sy + r_ay[p];
        end
        w_total = '0;
        for (int j = 0; j < NP; j++) begin
            w_total = w_total + SUM_W'(r_w[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (go[k]) begin
                    r_v[k] <= vin[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go[ST_W]) begin
            r_w <= n_w;
        end
        if (go[ST_M]) begin
            for (int j = 0; j < NP; j++) begin
                r_px[j] <= PR_W'(r_w[j]) * PR_W'(i_points[j].x);
                r_py[j] <= PR_W'(r_w[j]) * PR_W'(i_points[j].y);
            end
        end
        if (go[ST_A1]) begin
            r_ax <= n_ax;
            r_ay <= n_ay;
        end
        if (go[ST_A2]) begin
            r_sx <= n_sx;
            r_sy <= n_sy;
        end
        if (go[ST_O]) begin
            r_cx <= sat_round(r_sx);
            r_cy <= sat_round(r_sy);
        end
    end

    assign o_up_ready = go[0];
    assign o_dn_valid = r_v[ST_O];
    assign o_coord_x  = r_cx;
    assign o_coord_y  = r_cy;

    `BPE_ASSERT_COMB(a_bl_full, !go[0], (&r_v) && !i_dn_ready)
    `BPE_ASSERT_COMB(a_bl_unity, r_v[ST_W], w_total == ONE_W)

endmodule

// ===== rtl/core/bezier_point_evaluator_core.sv =====
// ----------------------------------------------------------------------------
// bezier_point_evaluator_core
// Evaluates a planar Bezier curve of degree 1 to MAX_DEGREE at parameter t
// (unsigned, FRACTION_BITS fraction bits, saturated to 1.0) and returns one
// signed Q16.16 (x, y) point per transaction, rounded and saturated to 32 bits.
// A new parameter is accepted every cycle while the input is not stalled; it
// passes through the chain of rounded power multiplies (one register stage per
// power) followed by the weight, product, two summing and output stages.
// Backpressure only stalls the input once every stage holds a transaction.
// Degree and the control points sit in APB registers at byte address 8*i and
// must only be written while no transaction is in flight.
// ----------------------------------------------------------------------------
module bezier_point_evaluator_core
    import bpe_pkg::*;
#(
    parameter int MAX_DEGREE    = 5,
    parameter int FRACTION_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bpe_param_if.sink             i_param,
    bpe_coord_if.source           o_coord,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [CFG_ADDR_W-1:0] i_paddr,
    input  logic [CFG_DATA_W-1:0] i_pwdata,
    output logic [CFG_DATA_W-1:0] o_prdata,
    output logic                  o_pready
);

    localparam int T_W = FRACTION_BITS + 1;

    logic [T_W-1:0]   s_t;
    logic [DEG_W-1:0] s_degree;
    t_point           s_points [MAX_DEGREE+1];
    logic             s_pw_valid;
    logic             s_pw_ready;
    logic [T_W-1:0]   s_pw [MAX_DEGREE+1];

    assign s_t = i_param.param_t;

    bpe_regs #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_degree  (s_degree),
        .o_points  (s_points)
    );

    bpe_powers #(
        .MAX_DEGREE    (MAX_DEGREE),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_powers (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_up_valid (i_param.valid),
        .o_up_ready (i_param.ready),
        .i_t        (s_t),
        .o_dn_valid (s_pw_valid),
        .i_dn_ready (s_pw_ready),
        .o_pw       (s_pw)
    );

    bpe_blend #(
        .MAX_DEGREE    (MAX_DEGREE),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_blend (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_up_valid (s_pw_valid),
        .o_up_ready (s_pw_ready),
        .i_pw       (s_pw),
        .i_degree   (s_degree),
        .i_points   (s_points),
        .o_dn_valid (o_coord.valid),
        .i_dn_ready (o_coord.ready),
        .o_coord_x  (o_coord.coord_x),
        .o_coord_y  (o_coord.coord_y)
    );

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// bezier point evaluator testbench
// Runs a table of directed parameters and register settings, then about 550
// random parameters over changing degrees and control points. Every curve
// point is checked against its pinned value or a predictor built from the
// Bernstein form, while both stream sides idle and stall at random in most phases.
// ----------------------------------------------------------------------------
module testbench;
    import bpe_pkg::*;

    localparam int PARAM_W     = 17;
    localparam int FRAC        = 16;
    localparam int DEG_LIMIT   = 5;
    localparam int PIPE_DEPTH  = DEG_LIMIT + 5;
    localparam int CLK_HALF    = 5;
    localparam int RESET_CYC   = 5;
    localparam int STALL_LIMIT = 2000;
    localparam int NUM_PHASES  = 11;
    localparam int PHASE_ITEMS = 50;

    localparam longint ONE_Q = 64'sd65536;

    localparam logic [PARAM_W-1:0] T_ZERO = 17'd0;
    localparam logic [PARAM_W-1:0] T_HALF = 17'd32768;
    localparam logic [PARAM_W-1:0] T_ONE  = 17'd65536;
    localparam logic [PARAM_W-1:0] T_FULL = 17'h1FFFF;

    localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;

    localparam logic [CFG_IDX_W-1:0] REG_POINT_ONE   = REG_POINT_ZERO + 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_TWO   = REG_POINT_ZERO + 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_THREE = REG_POINT_ZERO + 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_FOUR  = REG_POINT_ZERO + 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_FIVE  = REG_POINT_ZERO + 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_NONE        = 3'd7;

    localparam t_point NO_PT = '{32'sd0, 32'sd0};
    localparam t_point PNT0  = '{32'sh0001_0000, -32'sh0002_0000};
    localparam t_point PNT1  = '{32'sh0003_0000, 32'sh0004_0000};
    localparam t_point PNT2  = '{C_MAX, C_MIN};
    localparam t_point PNT3  = '{C_MIN, C_MAX};
    localparam t_point PNT4  = '{-32'sd1, -32'sd1};
    localparam t_point PNT5  = '{32'sh1234_5678, -32'sh6543_2110};

    typedef enum logic {ROW_WRITE, ROW_ITEM} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [PARAM_W-1:0]    t;
        logic                  pinned;
        t_point                want;
    } t_row;

    localparam int ROW_COUNT = 38;

    // pinned rows carry a point that follows directly from the settings
    localparam t_row DIRECTED [ROW_COUNT] = '{
        '{ROW_ITEM,  REG_DEGREE,      64'd0, T_ZERO,  1'b1, NO_PT},
        '{ROW_ITEM,  REG_DEGREE,      64'd0, T_FULL,  1'b1, NO_PT},
        '{ROW_WRITE, REG_POINT_ZERO,  PNT0,  T_ZERO,  1'b0, NO_PT},
        '{ROW_WRITE, REG_POINT_ONE,   PNT1,  T_ZERO,  1'b0, NO_PT},
        '{ROW_WRITE, REG_POINT_TWO,   PNT2,  T_ZERO,  1'b0, NO_PT},
        '{ROW_WRITE, REG_POINT_THREE, PNT3,  T_ZERO,  1'b0, NO_PT},
        '{ROW_WRITE, REG_POINT_FOUR,  PNT4,  T_ZERO,  1'b0, NO_PT},
        '{ROW_WRITE, REG_POINT_FIVE,  PNT5,  T_ZERO,  1'b0, NO_PT},
        '{ROW_ITEM,  REG_DEGREE,      64'd0, T_ZERO,  1'b1, PNT0},
        '{ROW_ITEM,  REG_DEGREE,      64'd0, T_ONE,   1'b1, PNT1},
        '{ROW_ITEM,  REG_DEGREE,      64'd0, T_FULL,  1'b1, PNT1},
        '{ROW_ITEM,  REG_DEGREE,      64'd0, T_HALF,  1'b0, NO_PT},
        '{ROW_ITEM,  REG_DEGREE,      64'd0, 17'd1,   1'b0, NO_PT},
        '{ROW_WRITE, REG_NONE,        '1,    T_ZERO,  1'b0, NO_PT},
        '{ROW_ITEM,  REG_DEGREE,      64'd0, T_ONE,   1'b1, PNT1},
        '{ROW_WRITE, REG_DEGREE,      64'd0, T_ZERO,  1'b0, NO_PT},
        '{ROW_ITEM,  REG_DEGREE,      64'd0, T_ONE,   1'b1, PNT1},
        '{ROW_ITEM,  REG_DEGREE,      64'd0, 17'd16384, 1'b0, NO_PT},
        '{ROW_WRITE, REG_DEGREE,      64'd2, T_ZERO,  1'b0, NO_PT},
        '{ROW_ITEM,  REG_DEGREE,      64'd0, T_ZERO,  1'b1, PNT0},
        '{ROW_ITEM,  REG_DEGREE,      64'd0, T_ONE,   1'b1, PNT2},
        '{ROW_ITEM,  REG_DEGREE,      64'd0, 17'd21845, 1'b0, NO_PT},
        '{ROW_WRITE, REG_DEGREE,      64'd3, T_ZERO,  1'b0, NO_PT},
        '{ROW_ITEM,  REG_DEGREE,      64'd0, T_ONE,   1'b1, PNT3},
        '{ROW_ITEM,  REG_DEGREE,      64'd0, 17'd40000, 1'b0, NO_PT},
        '{ROW_WRITE, REG_DEGREE,      64'd4, T_ZERO,  1'b0, NO_PT},
        '{ROW_ITEM,  REG_DEGREE,      64'd0, T_ONE,   1'b1, PNT4},
        '{ROW_ITEM,  REG_DEGREE,      64'd0, 17'd12345, 1'b0, NO_PT},
        '{ROW_WRITE, REG_DEGREE,      64'd5, T_ZERO,  1'b0, NO_PT},
        '{ROW_ITEM,  REG_DEGREE,      64'd0, T_ONE,   1'b1, PNT5},
        '{ROW_ITEM,  REG_DEGREE,      64'd0, T_ZERO,  1'b1, PNT0},
        '{ROW_ITEM,  REG_DEGREE,      64'd0, 17'd65535, 1'b0, NO_PT},
        '{ROW_ITEM,  REG_DEGREE,      64'd0, 17'd2,   1'b0, NO_PT},
        '{ROW_WRITE, REG_DEGREE,      64'd6, T_ZERO,  1'b0, NO_PT},
        '{ROW_ITEM,  REG_DEGREE,      64'd0, T_ONE,   1'b1, PNT5},
        '{ROW_ITEM,  REG_DEGREE,      64'd0, T_HALF,  1'b0, NO_PT},
        '{ROW_WRITE, REG_DEGREE,      64'd7, T_ZERO,  1'b0, NO_PT},
        '{ROW_ITEM,  REG_DEGREE,      64'd0, T_FULL,  1'b1, PNT5}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    logic [DEG_W-1:0] cfg_degree;
    t_point           cfg_points [NUM_PTS];
    t_point           pending_points [$];

    int error_count;
    int quiet_cycles;
    int send_idle_pct;
    int recv_stall_pct;

    bpe_param_if #(.PARAM_W(PARAM_W)) param_ch ();
    bpe_coord_if coord_ch ();

    bezier_point_evaluator_core #(
        .MAX_DEGREE    (DEG_LIMIT),
        .FRACTION_BITS (FRAC)
    ) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_param   (param_ch),
        .o_coord   (coord_ch),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready)
    );

    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    function automatic longint round_q(input longint v);
        return (v + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_coord(input longint v);
        if (v > 64'sd2147483647) begin
            return C_MAX;
        end
        if (v < -64'sd2147483648) begin
            return C_MIN;
        end
        return COORD_W'(v);
    endfunction

    function automatic longint binom(input int n, input int k);
        longint r;
        r = 1;
        for (int m = 0; m < k; m++) begin
            r = r * (n - m) / (m + 1);
        end
        return r;
    endfunction

    // weight of point j in power i of the degree-n basis
    function automatic longint bernstein_coef(input int n, input int i, input int j);
        longint sign;
        sign = (((i - j) % 2) != 0) ? -64'sd1 : 64'sd1;
        return sign * binom(n, i) * binom(i, j);
    endfunction

    function automatic t_point curve_point(input logic [PARAM_W-1:0] t_in);
        longint t;
        longint w;
        longint acc_x;
        longint acc_y;
        longint pw [NUM_PTS];
        int     n;
        t_point res;
        n = int'(cfg_degree);
        if (n < 1) begin
            n = 1;
        end
        if (n > DEG_LIMIT) begin
            n = DEG_LIMIT;
        end
        t = longint'(t_in);
        if (t > ONE_Q) begin
            t = ONE_Q;
        end
        pw[0] = ONE_Q;
        for (int i = 1; i <= n; i++) begin
            pw[i] = round_q(pw[i-1] * t);
        end
        acc_x = 0;
        acc_y = 0;
        for (int j = 0; j <= n; j++) begin
            w = 0;
            for (int i = j; i <= n; i++) begin
                w += pw[i] * bernstein_coef(n, i, j);
            end
            acc_x += w * longint'(cfg_points[j].x);
            acc_y += w * longint'(cfg_points[j].y);
        end
        res.x = sat_coord(round_q(acc_x));
        res.y = sat_coord(round_q(acc_y));
        return res;
    endfunction

    function automatic logic [PARAM_W-1:0] pick_param();
        logic [PARAM_W-1:0] t;
        case ($urandom_range(0, 19))
            0:       t = T_ZERO;
            1:       t = T_ONE;
            2:       t = T_FULL;
            3:       t = T_ONE + 17'd1;
            4, 5, 6: t = PARAM_W'($urandom_range(65537, 131071));
            default: t = PARAM_W'($urandom_range(0, 65536));
        endcase
        return t;
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_coord(input bit extreme_only);
        logic signed [COORD_W-1:0] v;
        if (extreme_only) begin
            v = ($urandom_range(0, 1) != 0) ? C_MAX : C_MIN;
        end else begin
            case ($urandom_range(0, 7))
                0:       v = C_MAX;
                1:       v = C_MIN;
                2:       v = '0;
                3, 4, 5: v = $signed($urandom) >>> 10;
                default: v = $urandom;
            endcase
        end
        return v;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // one apb transfer; psel stays high when another transfer follows at once
    task automatic cfg_access(input logic wr, input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data,
                              output logic [CFG_DATA_W-1:0] rdata, input logic last);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= CFG_ADDR_W'({idx, 3'b000});
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        if (last) begin
            psel    <= 1'b0;
            penable <= 1'b0;
        end
        if (wr) begin
            if (idx == REG_DEGREE) begin
                cfg_degree = data[DEG_W-1:0];
            end else if (idx != REG_NONE) begin
                cfg_points[int'(idx) - int'(REG_POINT_ZERO)] = data;
            end
        end
    endtask

    task automatic send_param(input logic [PARAM_W-1:0] t, input logic pinned,
                              input t_point want);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            param_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        param_ch.valid   <= 1'b1;
        param_ch.param_t <= t;
        do @(posedge i_clk); while (!param_ch.ready);
        pending_points.insert(pending_points.size(), pinned ? want : curve_point(t));
    endtask

    task automatic wait_drain();
        param_ch.valid <= 1'b0;
        while (pending_points.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        coord_ch.ready <= i_rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin : point_check
        t_point want;
        if (i_rst_n && coord_ch.valid && coord_ch.ready) begin
            if (pending_points.size() == 0) begin
                report_mismatch("point with no transaction pending",
                                {coord_ch.coord_x, coord_ch.coord_y}, '0);
            end else begin
                want = pending_points.pop_front();
                if (coord_ch.coord_x !== want.x) begin
                    report_mismatch("coord_x", 64'(coord_ch.coord_x), 64'(want.x));
                end
                if (coord_ch.coord_y !== want.y) begin
                    report_mismatch("coord_y", 64'(coord_ch.coord_y), 64'(want.y));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (param_ch.valid && param_ch.ready)
                || (coord_ch.valid && coord_ch.ready) || (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        logic [CFG_DATA_W-1:0] rd;
        logic [CFG_DATA_W-1:0] want_rd;
        logic [CFG_DATA_W-1:0] got_rd;
        bit                    ext;
        int                    phase;
        int                    item;
        int                    k;

        error_count    = 0;
        send_idle_pct  = 17;
        recv_stall_pct = 79;
        cfg_degree     = DEGREE_RESET;
        for (k = 0; k < NUM_PTS; k++) begin
            cfg_points[k] = NO_PT;
        end
        i_rst_n          <= 1'b0;
        param_ch.valid   <= 1'b0;
        param_ch.param_t <= '0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        repeat (RESET_CYC) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < ROW_COUNT; k++) begin
            if (DIRECTED[k].kind == ROW_WRITE) begin
                if (k == 0 || DIRECTED[k-1].kind == ROW_ITEM) begin
                    wait_drain();
                end
                cfg_access(1'b1, DIRECTED[k].idx, DIRECTED[k].data, rd,
                           k + 1 == ROW_COUNT || DIRECTED[k+1].kind == ROW_ITEM);
            end else begin
                send_param(DIRECTED[k].t, DIRECTED[k].pinned, DIRECTED[k].want);
            end
        end

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase < 4) begin
                send_idle_pct  = 17;
                recv_stall_pct = 79;
            end else if (phase < 8) begin
                send_idle_pct  = 79;
                recv_stall_pct = 17;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            ext = (phase % 3) == 2;
            wait_drain();
            cfg_access(1'b1, REG_DEGREE,
                       (phase == 0) ? 64'd1 : (phase == 1) ? 64'd5 :
                       64'($urandom_range(0, 7)), rd, 1'b0);
            for (k = 0; k < NUM_PTS; k++) begin
                cfg_access(1'b1, REG_POINT_ZERO + CFG_IDX_W'(k),
                           {pick_coord(ext), pick_coord(ext)}, rd, 1'b0);
            end
            cfg_access(1'b1, REG_NONE, {$urandom, $urandom}, rd, 1'b0);
            for (k = 0; k <= NUM_PTS; k++) begin
                cfg_access(1'b0, CFG_IDX_W'(k), '0, rd, k == NUM_PTS);
                if (CFG_IDX_W'(k) == REG_DEGREE) begin
                    got_rd  = 64'(rd[DEG_W-1:0]);
                    want_rd = 64'(cfg_degree);
                end else begin
                    got_rd  = rd;
                    want_rd = cfg_points[k - int'(REG_POINT_ZERO)];
                end
                if (got_rd !== want_rd) begin
                    report_mismatch("register readback", got_rd, want_rd);
                end
            end
            for (item = 0; item < PHASE_ITEMS; item++) begin
                // hold the sender until the pipeline has emptied
                if (item == PHASE_ITEMS / 2 && (phase % 4) == 1) begin
                    wait_drain();
                end
                send_param(pick_param(), 1'b0, NO_PT);
            end
        end

        wait_drain();
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/bpe_pkg.sv
rtl/core/bpe_if.sv
rtl/core/bpe_regs.sv
rtl/core/bpe_powers.sv
rtl/core/bpe_blend.sv
rtl/core/bezier_point_evaluator_core.sv
test/testbench.sv
